/* sv/sobel_gradient_direction_macros.svh */
// Assertion macros for the Sobel gradient direction block.
`ifndef SOBEL_GRADIENT_DIRECTION_MACROS_SVH
`define SOBEL_GRADIENT_DIRECTION_MACROS_SVH

`ifndef SYNTH
// Property that must hold in every cycle out of reset.
`define SGD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sgd assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgd assertion failed");
`else
`define SGD_ASSERT(lbl, clk, rst_n, prop)
`define SGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* sv/sgd_pkg.sv */
// Shared constants for the Sobel gradient direction block.
`default_nettype none

package sgd_pkg;

  localparam int unsigned PIXEL_BITS = 8;
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned IDX_W      = $clog2(MAX_WIDTH);
  localparam int unsigned FILL_W     = IDX_W + 1;
  localparam int unsigned CFG_W      = 12;
  localparam int unsigned GRAD_W     = PIXEL_BITS + 3;
  localparam int unsigned ABS_W      = PIXEL_BITS + 2;
  localparam int unsigned OUT_W      = 8;

  localparam int unsigned LO_SLOPE   = 106;
  localparam int unsigned HI_SLOPE   = 618;
  localparam int unsigned MAG_MAX    = 255;

  localparam logic [CFG_W-1:0] ROWS_RESET = 12'd480;
  localparam logic [CFG_W-1:0] COLS_RESET = 12'd640;

  localparam logic [OUT_W-1:0] DIR_0   = 8'd0;
  localparam logic [OUT_W-1:0] DIR_45  = 8'd45;
  localparam logic [OUT_W-1:0] DIR_90  = 8'd90;
  localparam logic [OUT_W-1:0] DIR_135 = 8'd135;

  // Register select: paddr bit 2
  localparam logic REG_FRAME_ROWS = 1'b0;
  localparam logic REG_FRAME_COLS = 1'b1;

endpackage

`default_nettype wire

/* sv/sgd_pix_if.sv */
// Pixel input channel.
`default_nettype none

interface sgd_pix_if;
  import sgd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

/* sv/sgd_res_if.sv */
// Gradient result channel.
`default_nettype none

interface sgd_res_if;
  import sgd_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] magnitude;
  logic [OUT_W-1:0] direction_deg;
  logic             frame_end;

  modport source (output valid, output magnitude, output direction_deg, output frame_end,
                  input ready);
  modport sink   (input valid, input magnitude, input direction_deg, input frame_end,
                  output ready);
endinterface

`default_nettype wire

/* sv/sobel_gradient_direction.sv */
// Sobel 3x3 gradient magnitude and quantised direction over a raster pixel stream.
// One pixel is taken every clock and its result is loaded into the output register through
// line-store read, window/gradient and magnitude/direction stages; the whole pipe stalls
// only while a result waits at the output. The line stores come up reading zero at once
// after reset (a fill mark tracks the written prefix), the window runs straight across row
// and frame ends with no border handling, and frame_end marks the last pixel of each frame
// of frame_rows x frame_cols. Registers: frame_rows at byte 0, frame_cols at byte 4, low
// 12 bits; write them only while the block is idle.
`default_nettype none
`include "sobel_gradient_direction_macros.svh"

module sobel_gradient_direction (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sgd_pix_if.sink          pix_i,
  sgd_res_if.source        res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import sgd_pkg::*;

  // configuration
  logic [CFG_W-1:0] rows_q, cols_q;
  logic [CFG_W-1:0] rows_eff, cols_eff;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_ROWS: rows_q <= pwdata[CFG_W-1:0];
        REG_FRAME_COLS: cols_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_ROWS: prdata = {{(32-CFG_W){1'b0}}, rows_q};
      REG_FRAME_COLS: prdata = {{(32-CFG_W){1'b0}}, cols_q};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (cols_q == '0) begin
      cols_eff = CFG_W'(1);
    end else if (cols_q > CFG_W'(MAX_WIDTH)) begin
      cols_eff = CFG_W'(MAX_WIDTH);
    end else begin
      cols_eff = cols_q;
    end
    rows_eff = (rows_q == '0) ? CFG_W'(1) : rows_q;
  end

  // handshake and pipe advance
  logic adv, accept;
  logic out_valid_q;

  assign adv         = !out_valid_q || res_o.ready;
  assign pix_i.ready = adv;
  assign accept      = pix_i.valid && adv;

  // raster counters
  logic [IDX_W-1:0] col_q, col_d;
  logic [CFG_W-1:0] row_q, row_d;
  logic             last_col, last_row, fend_d;

  assign last_col = ({1'b0, col_q} + CFG_W'(1)) >= cols_eff;
  assign last_row = ({1'b0, row_q} + (CFG_W + 1)'(1)) >= {1'b0, rows_eff};
  assign fend_d   = last_col && last_row;

  always_comb begin
    col_d = col_q + IDX_W'(1);
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + CFG_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores; entries at or above fill_q have never been written and read as zero
  logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] rd_older_q, rd_newer_q;
  logic [FILL_W-1:0]     fill_q, idx_inc;
  logic                  rd_ok;

  assign idx_inc = {1'b0, col_q} + FILL_W'(1);
  assign rd_ok   = {1'b0, col_q} < fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept && (idx_inc > fill_q)) begin
      fill_q <= idx_inc;
    end
  end

  // stage 1: read data back from the stores
  logic                  s1_v_q, s1_new_q, s1_ok_q, s1_fwd_q, s1_fend_q;
  logic [IDX_W-1:0]      s1_idx_q;
  logic [PIXEL_BITS-1:0] s1_px_q, s1_fwd_val_q;
  logic [PIXEL_BITS-1:0] top_eff, mid_eff;
  logic                  fwd_hit;

  assign mid_eff = s1_ok_q ? rd_newer_q : '0;
  assign top_eff = s1_fwd_q ? s1_fwd_val_q : (s1_ok_q ? rd_older_q : '0);
  // previous beat's older-store write lands on the same edge as this read
  assign fwd_hit = s1_new_q && (s1_idx_q == col_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      newer_mem[col_q] <= pix_i.pixel;
      rd_newer_q       <= newer_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_older_q <= older_mem[col_q];
    end
    if (s1_new_q) begin
      older_mem[s1_idx_q] <= mid_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s1_new_q <= 1'b0;
    end else begin
      s1_new_q <= accept;
      if (adv) begin
        s1_v_q <= pix_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q     <= col_q;
      s1_px_q      <= pix_i.pixel;
      s1_ok_q      <= rd_ok;
      s1_fwd_q     <= fwd_hit;
      s1_fwd_val_q <= mid_eff;
      s1_fend_q    <= fend_d;
    end
  end

  // stage 2: window shift and gradients
  logic [PIXEL_BITS-1:0]    win_q [9];
  logic [PIXEL_BITS-1:0]    win_d [9];
  logic signed [GRAD_W-1:0] c [9];
  logic signed [GRAD_W-1:0] gx_d, gy_d, gx_q, gy_q;
  logic                     s2_v_q, s2_fend_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = top_eff;
    win_d[5] = mid_eff;
    win_d[8] = s1_px_q;
    for (int k = 0; k < 9; k++) begin
      c[k] = $signed({3'b000, win_d[k]});
    end
    gx_d = (c[2] - c[0]) + ((c[5] - c[3]) <<< 1) + (c[8] - c[6]);
    gy_d = (c[0] - c[6]) + ((c[1] - c[7]) <<< 1) + (c[2] - c[8]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (adv) begin
      s2_v_q <= s1_v_q;
      if (s1_v_q) begin
        for (int k = 0; k < 9; k++) begin
          win_q[k] <= win_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      gx_q      <= gx_d;
      gy_q      <= gy_d;
      s2_fend_q <= s1_fend_q;
    end
  end

  // stage 3: magnitude and direction into the output register
  logic [ABS_W-1:0]       ax, ay;
  logic [ABS_W:0]         mag_sum;
  logic [OUT_W-1:0]       mag_d, dir_d;
  logic [ABS_W+6:0]       prod_lo;
  logic [2*ABS_W-1:0]     prod_hi;
  logic                   gx_pos, gx_neg, gy_pos, gy_neg;
  logic [OUT_W-1:0]       mag_q, dir_q;
  logic                   fend_q;

  always_comb begin
    ax      = gx_q[GRAD_W-1] ? ABS_W'(-gx_q) : ABS_W'(gx_q);
    ay      = gy_q[GRAD_W-1] ? ABS_W'(-gy_q) : ABS_W'(gy_q);
    mag_sum = {1'b0, ax} + {1'b0, ay};
    mag_d   = (mag_sum > (ABS_W + 1)'(MAG_MAX)) ? OUT_W'(MAG_MAX) : mag_sum[OUT_W-1:0];
    prod_lo = (ABS_W + 7)'(ax) * (ABS_W + 7)'(LO_SLOPE);
    prod_hi = (2 * ABS_W)'(ax) * (2 * ABS_W)'(HI_SLOPE);
    gx_pos  = !gx_q[GRAD_W-1] && (gx_q != '0);
    gx_neg  = gx_q[GRAD_W-1];
    gy_pos  = !gy_q[GRAD_W-1] && (gy_q != '0);
    gy_neg  = gy_q[GRAD_W-1];
    if (ay < {1'b0, prod_lo[ABS_W+6:8]}) begin
      dir_d = DIR_0;
    end else if ({2'b00, ay} > prod_hi[2*ABS_W-1:8]) begin
      dir_d = DIR_90;
    end else if ((gx_pos && gy_pos) || (gx_neg && gy_neg)) begin
      dir_d = DIR_45;
    end else begin
      dir_d = DIR_135;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q) begin
      mag_q  <= mag_d;
      dir_q  <= dir_d;
      fend_q <= s2_fend_q;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.magnitude     = mag_q;
  assign res_o.direction_deg = dir_q;
  assign res_o.frame_end     = fend_q;

  // checks
  `SGD_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FILL_W'(MAX_WIDTH))
  `SGD_ASSERT(a_dir_code, clk_i, rst_ni,
    !out_valid_q || dir_q == DIR_0 || dir_q == DIR_45 || dir_q == DIR_90 || dir_q == DIR_135)
  `SGD_ASSERT(a_flat_dir, clk_i, rst_ni, !(out_valid_q && mag_q == '0) || dir_q == DIR_135)
  `SGD_ASSERT_NEXT(a_frame_wrap, clk_i, rst_ni, accept && fend_d, col_q == '0 && row_q == '0)

endmodule

`default_nettype wire
